FILE: hdl/rab_pkg.sv
// shared types, constants and helpers for the rgba alpha blend pipeline
package rab_pkg;

  // channel layout of a pixel word
  localparam int NumChan   = 4;
  localparam int NumColor  = 3;
  localparam int ChanW     = 8;
  localparam int ProdW     = 2 * ChanW;
  localparam int NumCells  = ChanW;

  localparam int ChRed   = 0;
  localparam int ChGreen = 1;
  localparam int ChBlue  = 2;
  localparam int ChAlpha = 3;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [NumChan-1:0][ChanW-1:0] pixel_t;
  typedef logic [NumColor-1:0][ChanW-1:0] color_t;

  // payload carried along the divider cell row
  typedef struct packed {
    color_t rem;     // partial remainder per color channel
    color_t low;     // dividend bits not yet consumed, msb first
    color_t quot;    // quotient bits produced so far
    chan_t  oa;      // result alpha, the divisor
    pixel_t src;     // source pixel for the copy and zero alpha cases
    logic   bypass;  // blending disabled for this transaction
  } div_t;

  // floor(x / 255) for x up to 255 * 255
  function automatic chan_t div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] t;
    t = {1'b0, x} + {9'd0, x[ProdW-1:ChanW]} + {{ProdW{1'b0}}, 1'b1};
    return t[ProdW-1:ChanW];
  endfunction

endpackage

FILE: hdl/rgba_alpha_blend_unit.sv
// top level: rgba alpha blend, three prep stages then a row of divider cells
// 3 prep stages, then 8 divider cells, one quotient bit per channel per cell
// throughput: one pixel per cycle while out_ready is high
// every stage holds its own valid bit, so bubbles collapse under output stall
// reset (synchronous, active high) empties all stages and sets blend_enable to 1
module rgba_alpha_blend_unit import rab_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_write,
  input  logic  cfg_data,
  input  logic  in_valid,
  output logic  in_ready,
  input  chan_t src_red,
  input  chan_t src_green,
  input  chan_t src_blue,
  input  chan_t src_alpha,
  input  chan_t dst_red,
  input  chan_t dst_green,
  input  chan_t dst_blue,
  input  chan_t dst_alpha,
  output logic  out_valid,
  input  logic  out_ready,
  output chan_t out_red,
  output chan_t out_green,
  output chan_t out_blue,
  output chan_t out_alpha
);

  logic   blend_enable;
  pixel_t src_pix, dst_pix;
  logic   use_quot;
  div_t   last;

  logic [NumCells:0] chain_valid;
  logic [NumCells:0] chain_ready;
  div_t              chain_data [NumCells+1];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_enable <= 1'b1;
    end else if (cfg_write) begin
      blend_enable <= cfg_data;
    end
  end

  // pack pixel ports
  always_comb begin
    src_pix[ChRed]   = src_red;
    src_pix[ChGreen] = src_green;
    src_pix[ChBlue]  = src_blue;
    src_pix[ChAlpha] = src_alpha;
    dst_pix[ChRed]   = dst_red;
    dst_pix[ChGreen] = dst_green;
    dst_pix[ChBlue]  = dst_blue;
    dst_pix[ChAlpha] = dst_alpha;
  end

  // alpha and dividend pipeline
  rab_prep u_prep (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .src          (src_pix),
    .dst          (dst_pix),
    .blend_enable (blend_enable),
    .out_valid    (chain_valid[0]),
    .out_ready    (chain_ready[0]),
    .out_data     (chain_data[0])
  );

  // divider cell row
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rab_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_ready  (chain_ready[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_ready (chain_ready[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  assign chain_ready[NumCells] = out_ready;
  assign last                  = chain_data[NumCells];

  // result select: copy source on bypass or zero result alpha
  assign use_quot  = !last.bypass && (last.oa != '0);
  assign out_valid = chain_valid[NumCells];
  assign out_red   = use_quot ? last.quot[ChRed]   : last.src[ChRed];
  assign out_green = use_quot ? last.quot[ChGreen] : last.src[ChGreen];
  assign out_blue  = use_quot ? last.quot[ChBlue]  : last.src[ChBlue];
  assign out_alpha = last.bypass ? last.src[ChAlpha] : last.oa;

`ifndef NO_ASSERTIONS
  // input is refused only when every stage downstream holds a transaction
  a_full_when_stalled: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&chain_valid) && !out_ready)
    else $error("input stalled with a bubble in the pipeline");
`endif

endmodule

FILE: hdl/rab_prep.sv
// front pipeline: result alpha, channel weights and per-channel dividends
module rab_prep import rab_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  pixel_t src,
  input  pixel_t dst,
  input  logic   blend_enable,
  output logic   out_valid,
  input  logic   out_ready,
  output div_t   out_data
);

  // stage registers
  logic               v1, v2, v3;
  logic               rdy1, rdy2, rdy3;
  pixel_t             s1, s2;
  color_t             d1, d2;
  chan_t              d1_alpha;
  logic [ProdW-1:0]   p1;
  logic               byp1, byp2;
  chan_t              oa2, w2;
  div_t               data3;

  // combinational values between stages
  logic [ChanW:0]     oa_sum;
  chan_t              oa_next;
  logic [NumColor-1:0][ProdW-1:0] num;

  // per-stage ready: a stage moves when empty or when its successor moves
  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // result alpha: sa + da - floor(sa*da/255)
  assign oa_sum  = {1'b0, s1[ChAlpha]} + {1'b0, d1_alpha} - {1'b0, div255(p1)};
  assign oa_next = oa_sum[ChanW-1:0];

  // weighted sums s*sa + d*(oa-sa)
  always_comb begin
    for (int c = 0; c < NumColor; c++) begin
      num[c] = ProdW'(s2[c]) * ProdW'(s2[ChAlpha]) + ProdW'(d2[c]) * ProdW'(w2);
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // stage 1: capture pixels and the alpha product
  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      s1       <= src;
      d1       <= dst[NumColor-1:0];
      d1_alpha <= dst[ChAlpha];
      p1       <= ProdW'(src[ChAlpha]) * ProdW'(dst[ChAlpha]);
      byp1     <= !blend_enable;
    end
  end

  // stage 2: result alpha and destination weight
  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      s2   <= s1;
      d2   <= d1;
      oa2  <= oa_next;
      w2   <= oa_next - s1[ChAlpha];
      byp2 <= byp1;
    end
  end

  // stage 3: split each dividend into remainder seed and low bits
  always_ff @(posedge clk) begin
    if (v2 && rdy3) begin
      for (int c = 0; c < NumColor; c++) begin
        data3.rem[c] <= num[c][ProdW-1:ChanW];
        data3.low[c] <= num[c][ChanW-1:0];
      end
      data3.quot   <= '0;
      data3.oa     <= oa2;
      data3.src    <= s2;
      data3.bypass <= byp2;
    end
  end

  assign out_valid = v3;
  assign out_data  = data3;

`ifndef NO_ASSERTIONS
  // the destination weight never goes negative
  a_weight_nonneg: assert property (@(posedge clk) disable iff (rst)
    v2 && !byp2 |-> oa2 >= s2[ChAlpha])
    else $error("result alpha below source alpha");

  // quotient fits eight bits: the dividend high byte stays below the divisor
  a_quot_fits: assert property (@(posedge clk) disable iff (rst)
    v3 && !data3.bypass && data3.oa != '0 |->
      data3.rem[ChRed] < data3.oa && data3.rem[ChGreen] < data3.oa &&
      data3.rem[ChBlue] < data3.oa)
    else $error("dividend too large for an eight bit quotient");
`endif

endmodule

FILE: hdl/rab_div_cell.sv
// one restoring-division cell: one quotient bit per color channel
module rab_div_cell import rab_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  div_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output div_t out_data
);

  logic valid;
  div_t data;
  div_t data_next;
  logic [ChanW:0] trial;

  assign in_ready = !valid || out_ready;

  // shift in the next dividend bit and try to subtract the divisor
  always_comb begin
    data_next = in_data;
    trial     = '0;
    for (int c = 0; c < NumColor; c++) begin
      trial = {in_data.rem[c], in_data.low[c][ChanW-1]};
      data_next.low[c] = {in_data.low[c][ChanW-2:0], 1'b0};
      if (trial >= {1'b0, in_data.oa}) begin
        data_next.rem[c]  = ChanW'(trial - {1'b0, in_data.oa});
        data_next.quot[c] = {in_data.quot[c][ChanW-2:0], 1'b1};
      end else begin
        data_next.rem[c]  = trial[ChanW-1:0];
        data_next.quot[c] = {in_data.quot[c][ChanW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = valid;
  assign out_data  = data;

`ifndef NO_ASSERTIONS
  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    valid && !data.bypass && data.oa != '0 |->
      data.rem[ChRed] < data.oa && data.rem[ChGreen] < data.oa &&
      data.rem[ChBlue] < data.oa)
    else $error("partial remainder out of range");
`endif

endmodule
